// ===== rtl/mtg_pkg.sv =====
package mtg_pkg;

    localparam int MAX_PANELS_DEF  = 4;
    localparam int GRID_HEIGHT_DEF = 16;
    localparam int MAX_ANTS_DEF    = 6;
    localparam int MAX_RULE_DEF    = 8;

    localparam int PANEL_COLS  = 16;
    localparam int PANEL_SHIFT = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_RULE_TURNS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RULE_LENGTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANT_TOTAL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROUNDS      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_MODE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PANEL_TOTAL = 3'd5;

    localparam logic [7:0] RST_RULE_TURNS  = 8'd1;
    localparam logic [3:0] RST_RULE_LENGTH = 4'd2;
    localparam logic [2:0] RST_ANT_TOTAL   = 3'd1;
    localparam logic [5:0] RST_ROUNDS      = 6'd8;
    localparam logic       RST_WRAP_MODE   = 1'b1;
    localparam logic [2:0] RST_PANEL_TOTAL = 3'd3;

    localparam logic [5:0] ROUND_LIMIT = 6'd50;

    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_LEFT  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] read_x;
        logic [3:0] read_y;
    } req_item_t;

    typedef struct packed {
        logic [2:0] cell_color;
        logic       ant_present;
    } rsp_item_t;

    typedef struct packed {
        logic latch;
        logic place;
        logic clear_wr;
        logic fetch;
        logic update;
        logic ant_clr;
        logic ant_inc;
        logic round_clr;
        logic round_inc;
        logic look;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic ant_last;
        logic round_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/multi_ant_turmite_grid_unit.sv =====
// Multi-ant turmite grid: a color grid of 16 * panel_total columns by GRID_HEIGHT rows
// with up to MAX_ANTS ants.
// Request channel (req_valid / req_ready / req_data) takes one command per transfer:
// step a frame, reset the simulation, or read one cell. Every request yields exactly one
// transfer on the response channel (rsp_valid / rsp_ready / rsp_data); only a read
// carries a nonzero color or ant flag.
// A read looks up its cell in state S_LOOK; a step works through each ant in turn for
// every round, one read (S_FETCH) and one write (S_UPDATE) of the cell memory per ant;
// a reset command places the ants and then runs the clear sweep that writes one cell
// per cycle.
// One request is worked on at a time; req_ready is high only while the block waits
// for a command, so the next transfer comes in the same cycle that rsp_valid rises at
// the earliest.
// After rst_n the cell memory is cleared in a sweep over all DEPTH cells (1024 at the
// default size) with req_ready low; configuration writes are taken during the sweep.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr.
// When the receiver stalls, the result waits in the output register; the next request
// is still taken and worked on, and its result is loaded once the old one transfers.
module multi_ant_turmite_grid_unit #(
    parameter int MAX_PANELS  = mtg_pkg::MAX_PANELS_DEF,
    parameter int GRID_HEIGHT = mtg_pkg::GRID_HEIGHT_DEF,
    parameter int MAX_ANTS    = mtg_pkg::MAX_ANTS_DEF,
    parameter int MAX_RULE    = mtg_pkg::MAX_RULE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  mtg_pkg::req_item_t             req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output mtg_pkg::rsp_item_t             rsp_data,
    input  logic                           cfg_we,
    input  logic [mtg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mtg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mtg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_cmd   (req_data.cmd),
        .status    (status),
        .cmd       (cmd)
    );

    mtg_dp #(
        .MAX_PANELS  (MAX_PANELS),
        .GRID_HEIGHT (GRID_HEIGHT),
        .MAX_ANTS    (MAX_ANTS),
        .MAX_RULE    (MAX_RULE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== rtl/mtg_ctrl.sv =====
module mtg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_cmd,
    input  mtg_pkg::dp_status_t status,
    output mtg_pkg::ctrl_cmd_t  cmd
);
    import mtg_pkg::*;

    typedef enum logic [2:0] {
        S_INIT_CLEAR,
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_UPDATE,
        S_LOOK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_INIT_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch = 1'b1;
                    case (req_cmd)
                        CMD_STEP:
                        begin
                            cmd.ant_clr   = 1'b1;
                            cmd.round_clr = 1'b1;
                            state_next    = S_FETCH;
                        end
                        CMD_RESET:
                        begin
                            cmd.place  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.ant_last)
                begin
                    cmd.ant_clr = 1'b1;
                    if (status.round_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.round_inc = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
                else
                begin
                    cmd.ant_inc = 1'b1;
                    state_next  = S_FETCH;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mtg_dp.sv =====
module mtg_dp #(
    parameter int MAX_PANELS  = mtg_pkg::MAX_PANELS_DEF,
    parameter int GRID_HEIGHT = mtg_pkg::GRID_HEIGHT_DEF,
    parameter int MAX_ANTS    = mtg_pkg::MAX_ANTS_DEF,
    parameter int MAX_RULE    = mtg_pkg::MAX_RULE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mtg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mtg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  mtg_pkg::req_item_t                req_data,
    input  mtg_pkg::ctrl_cmd_t                cmd,
    output mtg_pkg::dp_status_t               status,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output mtg_pkg::rsp_item_t                rsp_data
);
    import mtg_pkg::*;

    localparam int X_W   = $clog2(MAX_PANELS * PANEL_COLS);
    localparam int Y_W   = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;
    localparam int P_W   = $clog2(MAX_PANELS + 1);
    localparam int N_W   = $clog2(MAX_ANTS + 1);
    localparam int A_W   = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
    localparam int CW    = $clog2(MAX_RULE);
    localparam int DEPTH = MAX_PANELS * PANEL_COLS * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int P_RST = (RST_PANEL_TOTAL > MAX_PANELS) ? MAX_PANELS : RST_PANEL_TOTAL;

    function automatic logic [AW-1:0] cell_addr(input logic [Y_W-1:0] y,
                                                input logic [X_W-1:0] x,
                                                input logic [P_W-1:0] p);
        logic [Y_W+P_W-1:0] yp;
        yp = (Y_W+P_W)'(y) * (Y_W+P_W)'(p);
        return AW'({yp, {PANEL_SHIFT{1'b0}}}) + AW'(x);
    endfunction

    function automatic logic [3:0] color_mod(input logic [CW-1:0] c, input logic [3:0] len);
        logic [CW+3:0] r;
        logic [CW+3:0] d;
        r = (CW+4)'(c);
        for (int i = CW - 1; i >= 0; i--)
        begin
            d = (CW+4)'(len) << i;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return 4'(r);
    endfunction

    function automatic logic [X_W-1:0] place_col(input logic [P_W-1:0] p,
                                                 input logic [4:0] idx);
        logic [X_W+1:0] full;
        logic [X_W+1:0] c;
        full = (X_W+2)'(p) << PANEL_SHIFT;
        c    = ((X_W+2)'(p) << (PANEL_SHIFT - 1)) + (X_W+2)'(idx);
        if (c >= full)
        begin
            c = c - full;
        end
        return X_W'(c);
    endfunction

    logic [7:0]     rule_turns_reg;
    logic [3:0]     rule_length_reg;
    logic [2:0]     ant_total_reg;
    logic [5:0]     rounds_reg;
    logic           wrap_mode_reg;
    logic [2:0]     panel_total_reg;

    logic [3:0]     len_sat;
    logic [N_W-1:0] ants_sat;
    logic [5:0]     rounds_sat;
    logic [P_W-1:0] p_sat;
    logic [X_W:0]   width;
    logic [X_W:0]   w_m1;

    logic [X_W-1:0] ant_col_reg     [MAX_ANTS];
    logic [Y_W-1:0] ant_row_reg     [MAX_ANTS];
    logic [1:0]     ant_heading_reg [MAX_ANTS];

    logic [AW-1:0]  sweep_cnt_reg;
    logic [A_W-1:0] ant_cnt_reg;
    logic [5:0]     round_cnt_reg;

    logic [CW-1:0]  cell_mem [DEPTH];
    logic [CW-1:0]  rd_data_reg;

    logic [AW-1:0]  addr_reg;
    logic [X_W-1:0] x0_reg;
    logic [Y_W-1:0] y0_reg;
    logic [1:0]     h_reg;
    logic           is_read_reg;
    logic [5:0]     rx_reg;
    logic [3:0]     ry_reg;

    logic           rsp_valid_reg;
    rsp_item_t      rsp_reg;

    logic [X_W-1:0] x_cur;
    logic [Y_W-1:0] y_cur;
    logic [X_W-1:0] x0;
    logic [Y_W-1:0] y0;
    logic [AW-1:0]  ant_addr;
    logic [AW-1:0]  look_addr;

    logic [3:0]     k;
    logic [4:0]     k1;
    logic           turn_left;
    logic [1:0]     h1;
    logic [CW-1:0]  new_color;
    logic [X_W-1:0] nx;
    logic [Y_W-1:0] ny;
    logic [1:0]     nh;

    logic           in_range;
    logic           hit;

    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [CW-1:0]  mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    always_comb
    begin
        if (rule_length_reg == 4'd0)
        begin
            len_sat = 4'd1;
        end
        else if (5'(rule_length_reg) > 5'(MAX_RULE))
        begin
            len_sat = 4'(MAX_RULE);
        end
        else
        begin
            len_sat = rule_length_reg;
        end

        if (ant_total_reg == 3'd0)
        begin
            ants_sat = N_W'(1);
        end
        else if (5'(ant_total_reg) > 5'(MAX_ANTS))
        begin
            ants_sat = N_W'(MAX_ANTS);
        end
        else
        begin
            ants_sat = N_W'(ant_total_reg);
        end

        if (rounds_reg == 6'd0)
        begin
            rounds_sat = 6'd1;
        end
        else if (rounds_reg > ROUND_LIMIT)
        begin
            rounds_sat = ROUND_LIMIT;
        end
        else
        begin
            rounds_sat = rounds_reg;
        end

        if (panel_total_reg == 3'd0)
        begin
            p_sat = P_W'(1);
        end
        else if (4'(panel_total_reg) > 4'(MAX_PANELS))
        begin
            p_sat = P_W'(MAX_PANELS);
        end
        else
        begin
            p_sat = P_W'(panel_total_reg);
        end

        width = (X_W+1)'(p_sat) << PANEL_SHIFT;
        w_m1  = width - (X_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_turns_reg  <= RST_RULE_TURNS;
            rule_length_reg <= RST_RULE_LENGTH;
            ant_total_reg   <= RST_ANT_TOTAL;
            rounds_reg      <= RST_ROUNDS;
            wrap_mode_reg   <= RST_WRAP_MODE;
            panel_total_reg <= RST_PANEL_TOTAL;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RULE_TURNS:  rule_turns_reg  <= cfg_wdata;
                REG_RULE_LENGTH: rule_length_reg <= cfg_wdata[3:0];
                REG_ANT_TOTAL:   ant_total_reg   <= cfg_wdata[2:0];
                REG_ROUNDS:      rounds_reg      <= cfg_wdata[5:0];
                REG_WRAP_MODE:   wrap_mode_reg   <= cfg_wdata[0];
                REG_PANEL_TOTAL: panel_total_reg <= cfg_wdata[2:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            ant_cnt_reg   <= '0;
            round_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + AW'(1);
            end
            if (cmd.ant_clr)
            begin
                ant_cnt_reg <= '0;
            end
            else if (cmd.ant_inc)
            begin
                ant_cnt_reg <= ant_cnt_reg + A_W'(1);
            end
            if (cmd.round_clr)
            begin
                round_cnt_reg <= '0;
            end
            else if (cmd.round_inc)
            begin
                round_cnt_reg <= round_cnt_reg + 6'd1;
            end
        end
    end

    assign status.sweep_last = (sweep_cnt_reg == AW'(DEPTH - 1));
    assign status.ant_last   = (ant_cnt_reg == A_W'(ants_sat - N_W'(1)));
    assign status.round_last = (round_cnt_reg == rounds_sat - 6'd1);
    assign status.out_free   = !rsp_valid_reg || rsp_ready;

    // fetch: pull the ant back onto the grid and form its cell address
    always_comb
    begin
        x_cur    = ant_col_reg[ant_cnt_reg];
        y_cur    = ant_row_reg[ant_cnt_reg];
        x0       = ((X_W+1)'(x_cur) >= width) ? X_W'(w_m1) : x_cur;
        y0       = ((Y_W+1)'(y_cur) >= (Y_W+1)'(GRID_HEIGHT)) ? Y_W'(GRID_HEIGHT - 1) : y_cur;
        ant_addr = cell_addr(y0, x0, p_sat);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            addr_reg <= ant_addr;
            x0_reg   <= x0;
            y0_reg   <= y0;
            h_reg    <= ant_heading_reg[ant_cnt_reg];
        end
        if (cmd.latch)
        begin
            is_read_reg <= (req_data.cmd == CMD_READ);
            rx_reg      <= req_data.read_x;
            ry_reg      <= req_data.read_y;
        end
    end

    // update: turn, advance the cell color, move one cell (without wrap, turn back at an edge)
    always_comb
    begin
        k         = color_mod(rd_data_reg, len_sat);
        k1        = 5'(k) + 5'd1;
        new_color = (k1 == 5'(len_sat)) ? '0 : CW'(k1);
        turn_left = !k[3] && rule_turns_reg[k[2:0]];
        h1        = turn_left ? (h_reg - 2'd1) : (h_reg + 2'd1);
        nx        = x0_reg;
        ny        = y0_reg;
        nh        = h1;
        case (h1)
            HEAD_UP:
            begin
                if (y0_reg == '0)
                begin
                    if (wrap_mode_reg)
                    begin
                        ny = Y_W'(GRID_HEIGHT - 1);
                    end
                    else
                    begin
                        nh = HEAD_DOWN;
                    end
                end
                else
                begin
                    ny = y0_reg - Y_W'(1);
                end
            end
            HEAD_RIGHT:
            begin
                if ((X_W+1)'(x0_reg) == w_m1)
                begin
                    if (wrap_mode_reg)
                    begin
                        nx = '0;
                    end
                    else
                    begin
                        nh = HEAD_LEFT;
                    end
                end
                else
                begin
                    nx = x0_reg + X_W'(1);
                end
            end
            HEAD_DOWN:
            begin
                if (y0_reg == Y_W'(GRID_HEIGHT - 1))
                begin
                    if (wrap_mode_reg)
                    begin
                        ny = '0;
                    end
                    else
                    begin
                        nh = HEAD_UP;
                    end
                end
                else
                begin
                    ny = y0_reg + Y_W'(1);
                end
            end
            HEAD_LEFT:
            begin
                if (x0_reg == '0)
                begin
                    if (wrap_mode_reg)
                    begin
                        nx = X_W'(w_m1);
                    end
                    else
                    begin
                        nh = HEAD_RIGHT;
                    end
                end
                else
                begin
                    nx = x0_reg - X_W'(1);
                end
            end
            default:
            begin
                nh = h1;
            end
        endcase
    end

    for (genvar i = 0; i < MAX_ANTS; i++)
    begin : g_ant
        localparam int ROW_RST  = (GRID_HEIGHT / 2 + i) % GRID_HEIGHT;
        localparam int HEAD_RST = i % 4;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ant_col_reg[i]     <= place_col(P_W'(P_RST), 5'(i));
                ant_row_reg[i]     <= Y_W'(ROW_RST);
                ant_heading_reg[i] <= 2'(HEAD_RST);
            end
            else if (cmd.place)
            begin
                ant_col_reg[i]     <= place_col(p_sat, 5'(i));
                ant_row_reg[i]     <= Y_W'(ROW_RST);
                ant_heading_reg[i] <= 2'(HEAD_RST);
            end
            else if (cmd.update && (ant_cnt_reg == A_W'(i)))
            begin
                ant_col_reg[i]     <= nx;
                ant_row_reg[i]     <= ny;
                ant_heading_reg[i] <= nh;
            end
        end
    end

    // read command: range check, address and ant match
    always_comb
    begin
        in_range  = (8'(rx_reg) < 8'(width)) && (7'(ry_reg) < 7'(GRID_HEIGHT));
        look_addr = cell_addr(Y_W'(ry_reg), X_W'(rx_reg), p_sat);
        hit       = 1'b0;
        for (int i = 0; i < MAX_ANTS; i++)
        begin
            if ((N_W'(i) < ants_sat) && (ant_col_reg[i] == X_W'(rx_reg))
                && (ant_row_reg[i] == Y_W'(ry_reg)))
            begin
                hit = 1'b1;
            end
        end
    end

    assign mem_we = cmd.clear_wr || cmd.update;
    assign mem_wa = cmd.clear_wr ? sweep_cnt_reg : addr_reg;
    assign mem_wd = cmd.clear_wr ? '0 : new_color;
    assign mem_re = cmd.fetch || cmd.look;
    assign mem_ra = cmd.fetch ? ant_addr : look_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            rsp_reg.cell_color  <= (is_read_reg && in_range) ? 3'(rd_data_reg) : 3'd0;
            rsp_reg.ant_present <= is_read_reg && in_range && hit;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ===== rtl/mtg_checker.sv =====
module mtg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input mtg_pkg::rsp_item_t rsp_data
);
    import mtg_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_xfer && !req_xfer)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> !req_ready)
        else $error("request taken while a command is in progress");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("response without a request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many requests without response");

endmodule

bind multi_ant_turmite_grid_unit mtg_checker u_mtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
